@@ hdl/deferred_release_queue_core_macros.svh @@
// Assertion shorthands shared by the RTL. Each one samples on clk and
// is disabled while rst_n is low.
`ifndef DEFERRED_RELEASE_QUEUE_CORE_MACROS_SVH
`define DEFERRED_RELEASE_QUEUE_CORE_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define DRQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define DRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/drq_pkg.sv @@
package drq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam logic [IDX_W-1:0] FULL_COUNT  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [7:0]       RESET_DELAY = 8'd2;

    localparam logic [1:0] OP_ENQUEUE   = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_SET_DELAY = 2'd2;

    localparam logic [1:0] CAUSE_EXPIRED    = 2'd0;
    localparam logic [1:0] CAUSE_FULL       = 2'd1;
    localparam logic [1:0] CAUSE_FLUSH      = 2'd2;
    localparam logic [1:0] CAUSE_ZERO_DELAY = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
        logic [7:0]  new_delay;
    } cmd_t;

    typedef struct packed {
        logic [31:0] release_address;
        logic [1:0]  release_cause;
        logic        last_of_run;
    } rel_t;

    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  ticks;
    } entry_t;

endpackage

@@ hdl/deferred_release_queue_core.sv @@
// Deferred-release queue core.
//
// Command channel (cmd_valid / cmd_stall / cmd): a transfer carries one
// operation: enqueue an address, tick, or set the release delay. Release
// channel (rel_valid / rel_stall / rel): one transfer per released address,
// with its cause and a last_of_run flag that marks the final release a
// command produces. A command that releases nothing produces no transfer.
//
// Entries live in one synchronous table RAM (address plus 8-bit countdown).
// Commands are taken one at a time; cmd_stall stays high while a command is
// still being worked on. Enqueue, set delay and unused codes finish in idle,
// but for a zero delay with entries stored. An immediate release shows on rel
// in the cycle after the command transfer. A tick visits each stored entry
// once (RAM read, then update) and ends with a closing step. A flush to zero
// delay reads and releases each stored entry in turn, through the RAM port.
// When rel_stall holds the output register full, the sequencer waits in
// place at the next release; the command side stays stalled meanwhile.
// Reset empties the table (count to zero), sets the delay to 2 and drops
// any pending release; the RAM contents are not cleared.

`include "deferred_release_queue_core_macros.svh"

module deferred_release_queue_core
    import drq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,

    output logic rel_valid,
    input  logic rel_stall,
    output rel_t rel
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TK_RD  = 3'd1;
    localparam logic [2:0] ST_TK_EX  = 3'd2;
    localparam logic [2:0] ST_TK_END = 3'd3;
    localparam logic [2:0] ST_FL_RD  = 3'd4;
    localparam logic [2:0] ST_FL_EX  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       delay_reg, delay_next;

    // Tick releases are held back one step so last_of_run is known
    // before the release leaves the block.
    logic             pend_valid_reg, pend_valid_next;
    logic [31:0]      pend_addr_reg, pend_addr_next;

    logic             out_valid_reg;
    rel_t             out_reg;
    logic             out_free;
    logic             push;
    rel_t             push_data;
    logic             accept;

    // Table RAM: one write port, two registered read ports.
    entry_t           mem [QUEUE_DEPTH];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_a_addr;
    logic [IDX_W-1:0] rd_b_addr;
    entry_t           rd_a_reg;
    entry_t           rd_b_reg;
    logic [7:0]       dec_ticks;

    assign out_free  = !out_valid_reg || !rel_stall;
    assign cmd_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;
    assign rel_valid = out_valid_reg;
    assign rel       = out_reg;
    assign dec_ticks = rd_a_reg.ticks - 8'd1;

    // A write in the update state always lands before the next read is
    // issued, so the read-modify-write loop needs no forwarding.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        delay_next      = delay_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        push            = 1'b0;
        push_data       = '0;
        wr_en           = 1'b0;
        wr_addr         = count_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_a_addr       = idx_reg;
        rd_b_addr       = count_reg - IDX_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.operation)
                        OP_ENQUEUE:
                        begin
                            // Full table wins over zero delay.
                            if (count_reg == FULL_COUNT)
                            begin
                                push      = 1'b1;
                                push_data = '{release_address: cmd.address,
                                              release_cause:   CAUSE_FULL,
                                              last_of_run:     1'b1};
                            end
                            else if (delay_reg == 8'd0)
                            begin
                                push      = 1'b1;
                                push_data = '{release_address: cmd.address,
                                              release_cause:   CAUSE_ZERO_DELAY,
                                              last_of_run:     1'b1};
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg;
                                wr_data    = '{address: cmd.address, ticks: delay_reg};
                                count_next = count_reg + IDX_W'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = ST_TK_RD;
                            end
                        end
                        OP_SET_DELAY:
                        begin
                            delay_next = cmd.new_delay;
                            if ((cmd.new_delay == 8'd0) && (count_reg != '0))
                            begin
                                state_next = ST_FL_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_TK_RD:
            begin
                // Fetch the entry under examination and the last entry.
                rd_en      = 1'b1;
                state_next = ST_TK_EX;
            end

            ST_TK_EX:
            begin
                if (dec_ticks != 8'd0)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = '{address: rd_a_reg.address, ticks: dec_ticks};
                    idx_next = idx_reg + IDX_W'(1);
                    if (({1'b0, idx_reg} + (IDX_W+1)'(1)) < {1'b0, count_reg})
                    begin
                        state_next = ST_TK_RD;
                    end
                    else
                    begin
                        state_next = ST_TK_END;
                    end
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // Release the held address, hold this one, and move
                    // the last entry into the freed slot.
                    if (pend_valid_reg)
                    begin
                        push      = 1'b1;
                        push_data = '{release_address: pend_addr_reg,
                                      release_cause:   CAUSE_EXPIRED,
                                      last_of_run:     1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_addr_next  = rd_a_reg.address;
                    wr_en           = 1'b1;
                    wr_addr         = idx_reg;
                    wr_data         = rd_b_reg;
                    count_next      = count_reg - IDX_W'(1);
                    if (idx_reg < (count_reg - IDX_W'(1)))
                    begin
                        state_next = ST_TK_RD;
                    end
                    else
                    begin
                        state_next = ST_TK_END;
                    end
                end
            end

            ST_TK_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_data       = '{release_address: pend_addr_reg,
                                        release_cause:   CAUSE_EXPIRED,
                                        last_of_run:     1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_FL_RD:
            begin
                // Flush walks from the highest index down.
                rd_en      = 1'b1;
                rd_a_addr  = count_reg - IDX_W'(1);
                state_next = ST_FL_EX;
            end

            ST_FL_EX:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_data  = '{release_address: rd_a_reg.address,
                                   release_cause:   CAUSE_FLUSH,
                                   last_of_run:     (count_reg == IDX_W'(1))};
                    count_next = count_reg - IDX_W'(1);
                    if (count_reg == IDX_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FL_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            delay_reg      <= RESET_DELAY;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            delay_reg      <= delay_next;
            pend_valid_reg <= pend_valid_next;
            if (out_free)
            begin
                out_valid_reg <= push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        if (out_free && push)
        begin
            out_reg <= push_data;
        end
    end

    `DRQ_ASSERT_IMP(a_idle_no_pending, state_reg == ST_IDLE, !pend_valid_reg,
        "pending tick release left behind in idle")
    `DRQ_ASSERT_IMP(a_tick_index_in_range, state_reg == ST_TK_EX, idx_reg < count_reg,
        "tick walk index beyond entry count")
    `DRQ_ASSERT_IMP(a_flush_empties, (state_reg == ST_IDLE) && ($past(state_reg) == ST_FL_EX),
        count_reg == '0, "flush finished with entries left")
    `DRQ_ASSERT_NEXT(a_push_lands, out_free && push, rel_valid,
        "release pushed but output register empty")

endmodule
